// ===== rtl/sird_pkg.sv =====
`default_nettype none
package sird_pkg;

    localparam int MAX_RADIX_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 7;
    localparam int RADIX_W   = 5;
    localparam int ALPHA_W   = 64;
    localparam int DIGIT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W    = 8;
    localparam int ALPHA_CHARS = 16;

    // bits of the dividend consumed per division cycle
    localparam int DIV_BITS = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd2;

    localparam logic [BYTE_W-1:0] CHAR_PLUS     = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS    = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_PRINT_LO = 8'd33;
    localparam logic [BYTE_W-1:0] CHAR_PRINT_HI = 8'd126;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic div_done;
        logic quot_zero;
        logic last_digit;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/sird_ifs.sv =====
`default_nettype none
interface sird_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sird_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sird_out_if;
    logic                        valid;
    logic                        ready;
    logic [sird_pkg::CHAR_W-1:0] character;
    logic                        last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface sird_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sird_pkg::CFG_IDX_W-1:0] index;
    logic [sird_pkg::ALPHA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/signed_integer_to_radix_digits_top.sv =====
`default_nettype none
// Converts a signed VALUE_BITS-bit value to text in a programmable radix (2 to MAX_RADIX),
// most significant digit first, with a leading '-' for negative values; the last
// character of each value has last_char set. Digits come from a 16-entry alphabet
// (registers 1 and 2, digit 0 in the lowest byte); register 0 sets the radix. A radix
// out of range, or a used character that repeats, is outside 33..126, or is '+' or '-',
// makes the value produce no characters. Each digit is the remainder of a division in the
// shared divide-by-radix unit, which retires 8 dividend bits per cycle. Each character
// then leaves through the output register, which holds it until downstream is ready. One
// value is converted at a time; the next is taken while the final character waits
// downstream. Configuration writes are always accepted but only allowed while the block
// is idle.
module signed_integer_to_radix_digits_top #(
    parameter int MAX_RADIX  = sird_pkg::MAX_RADIX_DEF,
    parameter int VALUE_BITS = sird_pkg::VALUE_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sird_cfg_if.sink    cfg,
    sird_in_if.sink     value_ch,
    sird_out_if.source  char_ch
);

    sird_pkg::dp_cmd_t    cmd;
    sird_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    sird_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (value_ch.valid),
        .in_ready (value_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sird_datapath #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .value     (value_ch.value),
        .cmd       (cmd),
        .status    (status),
        .out_ready (char_ch.ready),
        .out_valid (char_ch.valid),
        .character (char_ch.character),
        .last_char (char_ch.last_char)
    );

endmodule
`default_nettype wire

// ===== rtl/sird_datapath.sv =====
`default_nettype none
module sird_datapath #(
    parameter int MAX_RADIX  = sird_pkg::MAX_RADIX_DEF,
    parameter int VALUE_BITS = sird_pkg::VALUE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    input  wire logic [sird_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sird_pkg::ALPHA_W-1:0]     cfg_data,
    input  wire logic signed [sird_pkg::VALUE_W-1:0] value,
    input  wire sird_pkg::dp_cmd_t                cmd,
    output sird_pkg::dp_status_t                  status,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [sird_pkg::CHAR_W-1:0]           character,
    output logic                                  last_char
);

    localparam int DB         = sird_pkg::DIV_BITS;
    localparam int DIV_CYCLES = (VALUE_BITS + DB - 1) / DB;
    localparam int PAD_W      = DIV_CYCLES * DB;
    localparam int DCYC_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int BW         = sird_pkg::BYTE_W;
    localparam int DW         = sird_pkg::DIGIT_W;
    localparam int RW         = sird_pkg::RADIX_W;

    // configuration
    logic [RW-1:0]                   radix_reg;
    logic [sird_pkg::ALPHA_W-1:0]    alpha_lo_reg;
    logic [sird_pkg::ALPHA_W-1:0]    alpha_hi_reg;
    logic [2*sird_pkg::ALPHA_W-1:0]  alpha_all;
    logic                            ok_reg;
    logic                            ok_next;

    // conversion
    logic [PAD_W-1:0]   work_reg;
    logic [PAD_W-1:0]   work_next;
    logic [DW-1:0]      rem_reg;
    logic [DW-1:0]      rem_next;
    logic               neg_reg;
    logic [DCYC_W-1:0]  dcyc_reg;
    logic [CNT_W-1:0]   dcount_reg;
    logic [DW-1:0]      digit_buffer [VALUE_BITS];

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [DB-1:0]         qbits;
    logic [RW-1:0]         trial;
    logic [RW-1:0]         diff;
    logic                  div_done;
    logic [IDX_W-1:0]      rd_idx;
    logic [DW-1:0]         rd_digit;
    logic [BW-1:0]         rd_char;

    logic [sird_pkg::CHAR_W-1:0] char_reg;
    logic                        last_reg;
    logic                        out_valid_reg;

    assign alpha_all = {alpha_hi_reg, alpha_lo_reg};

    // alphabet check
    always_comb
    begin
        logic [BW-1:0] ci;
        logic [BW-1:0] cj;
        logic          used_i;
        logic          used_j;
        ok_next = (radix_reg >= RW'(2)) && (radix_reg <= RW'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            ci     = alpha_all[i*BW +: BW];
            used_i = RW'(i) < radix_reg;
            if (used_i && ((ci < sird_pkg::CHAR_PRINT_LO) || (ci > sird_pkg::CHAR_PRINT_HI) ||
                           (ci == sird_pkg::CHAR_PLUS) || (ci == sird_pkg::CHAR_MINUS)))
            begin
                ok_next = 1'b0;
            end
            for (int j = i + 1; j < MAX_RADIX; j++)
            begin
                cj     = alpha_all[j*BW +: BW];
                used_j = RW'(j) < radix_reg;
                if (used_i && used_j && (ci == cj))
                begin
                    ok_next = 1'b0;
                end
            end
        end
    end

    assign raw = value[VALUE_BITS-1:0];
    assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    // DB restoring division steps per cycle, small remainder
    always_comb
    begin
        rem_next = rem_reg;
        qbits    = '0;
        trial    = '0;
        diff     = '0;
        for (int i = 0; i < DB; i++)
        begin
            trial = {rem_next, work_reg[PAD_W-1-i]};
            diff  = trial - radix_reg;
            qbits[DB-1-i] = (trial >= radix_reg);
            rem_next = qbits[DB-1-i] ? diff[DW-1:0] : trial[DW-1:0];
        end
        work_next = (work_reg << DB) | PAD_W'(qbits);
    end

    assign div_done = (dcyc_reg == DCYC_W'(DIV_CYCLES - 1));

    assign rd_idx   = IDX_W'(dcount_reg - CNT_W'(1));
    assign rd_digit = digit_buffer[rd_idx];
    assign rd_char  = alpha_all[{rd_digit, 3'b000} +: BW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= '0;
            alpha_lo_reg  <= '0;
            alpha_hi_reg  <= '0;
            ok_reg        <= 1'b0;
            dcyc_reg      <= '0;
            dcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= ok_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sird_pkg::CFG_RADIX:    radix_reg    <= cfg_data[RW-1:0];
                    sird_pkg::CFG_ALPHA_LO: alpha_lo_reg <= cfg_data;
                    sird_pkg::CFG_ALPHA_HI: alpha_hi_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.load)
            begin
                dcyc_reg   <= '0;
                dcount_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                if (div_done)
                begin
                    dcyc_reg   <= '0;
                    dcount_reg <= dcount_reg + CNT_W'(1);
                end
                else
                begin
                    dcyc_reg <= dcyc_reg + DCYC_W'(1);
                end
            end
            else if (cmd.emit_digit)
            begin
                dcount_reg <= dcount_reg - CNT_W'(1);
            end

            if (cmd.emit_sign || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg <= PAD_W'(mag);
            rem_reg  <= '0;
            neg_reg  <= raw[VALUE_BITS-1];
        end
        else if (cmd.div_step)
        begin
            work_reg <= work_next;
            rem_reg  <= div_done ? '0 : rem_next;
            if (div_done)
            begin
                digit_buffer[dcount_reg[IDX_W-1:0]] <= rem_next;
            end
        end

        if (cmd.emit_sign)
        begin
            char_reg <= sird_pkg::CHAR_MINUS[sird_pkg::CHAR_W-1:0];
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= rd_char[sird_pkg::CHAR_W-1:0];
            last_reg <= (dcount_reg == CNT_W'(1));
        end
    end

    assign status.alpha_ok   = ok_reg;
    assign status.neg        = neg_reg;
    assign status.div_done   = div_done;
    assign status.quot_zero  = (work_next == '0);
    assign status.last_digit = (dcount_reg == CNT_W'(1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

endmodule
`default_nettype wire

// ===== rtl/sird_ctrl.sv =====
`default_nettype none
module sird_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sird_pkg::dp_status_t status,
    output sird_pkg::dp_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_SIGN   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.alpha_ok ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done && status.quot_zero)
                begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== test/signed_integer_to_radix_digits_top_tb.sv =====
`default_nettype none
module signed_integer_to_radix_digits_top_tb;

    localparam int VALUE_W       = sird_pkg::VALUE_W;
    localparam int CHAR_W        = sird_pkg::CHAR_W;
    localparam int RADIX_W       = sird_pkg::RADIX_W;
    localparam int ALPHA_W       = sird_pkg::ALPHA_W;
    localparam int DIGIT_W       = sird_pkg::DIGIT_W;
    localparam int CFG_IDX_W     = sird_pkg::CFG_IDX_W;
    localparam int BYTE_W        = sird_pkg::BYTE_W;
    localparam int ALPHA_CHARS   = sird_pkg::ALPHA_CHARS;
    localparam int MAX_RADIX_DEF = sird_pkg::MAX_RADIX_DEF;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = sird_pkg::CFG_RADIX;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = sird_pkg::CFG_ALPHA_LO;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = sird_pkg::CFG_ALPHA_HI;

    localparam logic [BYTE_W-1:0] CHAR_PLUS     = sird_pkg::CHAR_PLUS;
    localparam logic [BYTE_W-1:0] CHAR_MINUS    = sird_pkg::CHAR_MINUS;
    localparam logic [BYTE_W-1:0] CHAR_PRINT_LO = sird_pkg::CHAR_PRINT_LO;
    localparam logic [BYTE_W-1:0] CHAR_PRINT_HI = sird_pkg::CHAR_PRINT_HI;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_GUARD  = 200;
    localparam int RANDOM_ITEMS = 180;
    localparam int IDLE_PCT     = 27;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } text_char_t;

    logic clk;
    logic rst_n;

    sird_cfg_if cfg ();
    sird_in_if  value_ch ();
    sird_out_if char_ch ();

    signed_integer_to_radix_digits_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .value_ch (value_ch),
        .char_ch  (char_ch)
    );

    // shadow of the block's configuration
    logic [RADIX_W-1:0] cur_radix;
    logic [ALPHA_W-1:0] cur_alpha_lo;
    logic [ALPHA_W-1:0] cur_alpha_hi;

    text_char_t pending_chars[$];

    int errors;
    int cycles;
    int values_converted;
    int values_rejected;
    int chars_checked;
    int src_idle_pct;
    int snk_idle_pct;
    int sink_hold_request;
    int sink_hold_left;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] digit_glyph(int idx);
        return (idx < 8) ? cur_alpha_lo[idx*BYTE_W +: BYTE_W]
                         : cur_alpha_hi[(idx-8)*BYTE_W +: BYTE_W];
    endfunction

    function automatic bit glyphs_usable();
        logic [BYTE_W-1:0] c;
        if (cur_radix < 2 || cur_radix > MAX_RADIX_DEF)
            return 0;
        for (int i = 0; i < cur_radix; i++)
        begin
            c = digit_glyph(i);
            if (c < CHAR_PRINT_LO || c > CHAR_PRINT_HI || c == CHAR_PLUS || c == CHAR_MINUS)
                return 0;
            for (int j = i + 1; j < cur_radix; j++)
                if (digit_glyph(j) == c)
                    return 0;
        end
        return 1;
    endfunction

    task automatic expect_text(logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digs [VALUE_W];
        logic [BYTE_W-1:0]  g;
        text_char_t         tc;
        int                 n;
        if (!glyphs_usable())
        begin
            values_rejected++;
            return;
        end
        values_converted++;
        mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
        n = 0;
        do
        begin
            digs[n] = DIGIT_W'(mag % cur_radix);
            mag = mag / cur_radix;
            n++;
        end
        while (mag != 0);
        if (v[VALUE_W-1])
        begin
            tc.character = CHAR_MINUS[CHAR_W-1:0];
            tc.last_char = 1'b0;
            pending_chars.push_back(tc);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            g = digit_glyph(digs[i]);
            tc.character = g[CHAR_W-1:0];
            tc.last_char = (i == 0);
            pending_chars.push_back(tc);
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (sink_hold_request != 0)
        begin
            sink_hold_left = sink_hold_request;
            sink_hold_request = 0;
        end
        if (sink_hold_left > 0)
        begin
            sink_hold_left--;
            char_ch.ready <= 1'b0;
        end
        else
            char_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : check_chars
        text_char_t exp_c;
        if (rst_n && char_ch.valid && char_ch.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character transaction: character=%0d last_char=%0b",
                       char_ch.character, char_ch.last_char);
                errors++;
            end
            else
            begin
                exp_c = pending_chars.pop_front();
                chars_checked++;
                if (char_ch.character !== exp_c.character)
                begin
                    $error("character: expected %0d, actual %0d",
                           exp_c.character, char_ch.character);
                    errors++;
                end
                if (char_ch.last_char !== exp_c.last_char)
                begin
                    $error("last_char: expected %0b, actual %0b",
                           exp_c.last_char, char_ch.last_char);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input and config drivers; all calls start and end at a falling edge
    // ------------------------------------------------------------------
    task automatic send_value(logic signed [VALUE_W-1:0] v);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            value_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        do
            @(posedge clk);
        while (!value_ch.ready);
        expect_text(v);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        value_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_chars.size() != 0);
    endtask

    task automatic quiesce();
        wait_all_results();
        repeat (DRAIN_GUARD) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_RADIX:    cur_radix = data[RADIX_W-1:0];
            CFG_ALPHA_LO: cur_alpha_lo = data;
            CFG_ALPHA_HI: cur_alpha_hi = data;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_alphabet(logic [RADIX_W-1:0] r, logic [2*ALPHA_W-1:0] glyphs);
        logic [ALPHA_W-1:0] rdata;
        quiesce();
        rdata = {$urandom, $urandom};
        rdata[RADIX_W-1:0] = r;
        write_reg(CFG_RADIX, rdata);
        write_reg(CFG_ALPHA_LO, glyphs[ALPHA_W-1:0]);
        write_reg(CFG_ALPHA_HI, glyphs[2*ALPHA_W-1:ALPHA_W]);
    endtask

    // ------------------------------------------------------------------
    // alphabet and value generators
    // ------------------------------------------------------------------
    function automatic logic [2*ALPHA_W-1:0] glyphs_from(string s);
        logic [2*ALPHA_W-1:0] a;
        a = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < s.len(); i++)
            a[i*BYTE_W +: BYTE_W] = s[i];
        return a;
    endfunction

    function automatic logic [2*ALPHA_W-1:0] random_glyphs(int r);
        logic [2*ALPHA_W-1:0] a;
        logic [BYTE_W-1:0]    c;
        bit                   clash;
        a = '0;
        for (int i = 0; i < ALPHA_CHARS; i++)
        begin
            if (i >= r)
                a[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
            else
            begin
                do
                begin
                    c = BYTE_W'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
                    clash = (c == CHAR_PLUS || c == CHAR_MINUS);
                    for (int j = 0; j < i; j++)
                        if (a[j*BYTE_W +: BYTE_W] == c)
                            clash = 1;
                end
                while (clash);
                a[i*BYTE_W +: BYTE_W] = c;
            end
        end
        return a;
    endfunction

    function automatic logic [2*ALPHA_W-1:0] spoil_glyphs(logic [2*ALPHA_W-1:0] a, int r);
        int k;
        int j;
        k = $urandom_range(0, r - 1);
        case ($urandom_range(0, 4))
            0: a[k*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, CHAR_PRINT_LO - 1));
            1: a[k*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(CHAR_PRINT_HI + 1, 255));
            2: a[k*BYTE_W +: BYTE_W] = CHAR_PLUS;
            3: a[k*BYTE_W +: BYTE_W] = CHAR_MINUS;
            default:
            begin
                do
                    j = $urandom_range(0, r - 1);
                while (j == k);
                a[k*BYTE_W +: BYTE_W] = a[j*BYTE_W +: BYTE_W];
            end
        endcase
        return a;
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value(int r);
        logic signed [VALUE_W-1:0] p;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return $signed($urandom_range(0, 2 * r * r)) - r * r;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return {1'b1, {(VALUE_W-1){1'b0}}};
                    1: return {1'b0, {(VALUE_W-1){1'b1}}};
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default:
            begin
                p = 1;
                repeat ($urandom_range(1, 31))
                    if (p < 32'sh7fffffff / r)
                        p = p * r;
                p = p - $signed($urandom_range(0, 1));
                return $urandom_range(0, 1) ? -p : p;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_value(5);
        send_value(-5);
    endtask

    task automatic test_decimal_extremes();
        set_alphabet(10, glyphs_from("0123456789"));
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(-10);
        send_value(32'sh7fffffff);
        send_value({1'b1, {(VALUE_W-1){1'b0}}});
        send_value(32'sh55aa33cc);
    endtask

    task automatic test_radix_extremes();
        set_alphabet(2, glyphs_from("ab"));
        send_value({1'b1, {(VALUE_W-1){1'b0}}});
        send_value(32'sh7fffffff);
        send_value(0);
        set_alphabet(16, glyphs_from("0123456789ABCDEF"));
        send_value(-1);
        send_value({1'b1, {(VALUE_W-1){1'b0}}});
        send_value(32'sh7fffffff);
    endtask

    task automatic test_bad_alphabets();
        logic [2*ALPHA_W-1:0] dec;
        logic [2*ALPHA_W-1:0] bad;
        dec = glyphs_from("0123456789");
        set_alphabet(1, dec);
        send_value(123);
        set_alphabet(17, random_glyphs(16));
        send_value(-77);
        set_alphabet(31, random_glyphs(16));
        send_value(42);
        set_alphabet(10, glyphs_from("01234 6789"));
        send_value(456);
        bad = dec;
        bad[3*BYTE_W +: BYTE_W] = 8'd127;
        set_alphabet(10, bad);
        send_value(-3);
        set_alphabet(10, glyphs_from("0123+56789"));
        send_value(8);
        set_alphabet(10, glyphs_from("01234567-9"));
        send_value(8);
        set_alphabet(10, glyphs_from("0123456780"));
        send_value(11);
        bad = dec;
        bad[BYTE_W-1:0] = 8'd0;
        set_alphabet(10, bad);
        send_value(100);
        // an out-of-range register index must leave the alphabet alone
        set_alphabet(10, dec);
        write_reg(CFG_UNUSED, '0);
        send_value(-9876);
    endtask

    task automatic test_full_rate();
        int r;
        r = $urandom_range(2, MAX_RADIX_DEF);
        set_alphabet(RADIX_W'(r), random_glyphs(r));
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (40) send_value(random_value(r));
        wait_all_results();
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
    endtask

    task automatic test_output_stall();
        set_alphabet(10, glyphs_from("9876543210"));
        sink_hold_request = 400;
        repeat (12) send_value($urandom);
    endtask

    task automatic test_sender_pause();
        set_alphabet(7, random_glyphs(7));
        repeat (6) send_value(random_value(7));
        wait_all_results();
        repeat (6) send_value(random_value(7));
    endtask

    task automatic test_random_phases();
        int r;
        int sent;
        int n;
        logic [2*ALPHA_W-1:0] g;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    r = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                             : $urandom_range(MAX_RADIX_DEF + 1, 31);
                    set_alphabet(RADIX_W'(r), random_glyphs(ALPHA_CHARS));
                    repeat ($urandom_range(2, 4)) send_value($urandom);
                end
                1:
                begin
                    r = $urandom_range(2, MAX_RADIX_DEF);
                    set_alphabet(RADIX_W'(r), spoil_glyphs(random_glyphs(r), r));
                    repeat ($urandom_range(2, 4)) send_value($urandom);
                end
                default:
                begin
                    r = $urandom_range(2, MAX_RADIX_DEF);
                    g = random_glyphs(r);
                    set_alphabet(RADIX_W'(r), g);
                    n = $urandom_range(8, 24);
                    repeat (n) send_value(random_value(r));
                    sent += n;
                end
            endcase
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        values_converted = 0;
        values_rejected = 0;
        chars_checked = 0;
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
        sink_hold_request = 0;
        sink_hold_left = 0;
        cur_radix = '0;
        cur_alpha_lo = '0;
        cur_alpha_hi = '0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        char_ch.ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_decimal_extremes();
        test_radix_extremes();
        test_bad_alphabets();
        test_full_rate();
        test_output_stall();
        test_sender_pause();
        test_random_phases();
        quiesce();

        $display("converted %0d values into %0d characters, %0d values hit a rejected alphabet",
                 values_converted, chars_checked, values_rejected);
        $display("radix 0..31 probed, bad glyphs, full-rate bursts, long output stall, drain pause");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

// ===== signed_integer_to_radix_digits_top.f =====
rtl/sird_pkg.sv
rtl/sird_ifs.sv
rtl/sird_datapath.sv
rtl/sird_ctrl.sv
rtl/signed_integer_to_radix_digits_top.sv
test/signed_integer_to_radix_digits_top_tb.sv
